// ----- design/cte_pkg.sv -----
// shared types, codes and calendar helpers for the calendar time editor
package cte_pkg;

	localparam int JOY_W          = 12;
	localparam int ADC_BITS_DEF   = 12;
	localparam int CFG_IDX_W      = 1;
	localparam int IN_TDATA_W     = 72;
	localparam int IN_TUSER_W     = 2;
	localparam int OUT_TDATA_W    = 48;
	localparam int OUT_TUSER_W    = 1;

	localparam logic [JOY_W-1:0] JOY_LOW_RST  = 12'd1000;
	localparam logic [JOY_W-1:0] JOY_HIGH_RST = 12'd3000;

	localparam logic [13:0] YEAR_MAX   = 14'd9999;
	localparam logic [13:0] YEAR_RST   = 14'd2026;
	localparam logic [3:0]  MONTH_MAX  = 4'd12;
	localparam logic [4:0]  HOUR_MAX   = 5'd23;
	localparam logic [5:0]  MINSEC_MAX = 6'd59;

	typedef logic [1:0] action_t;
	localparam action_t ACT_TICK   = 2'd0;
	localparam action_t ACT_JOY    = 2'd1;
	localparam action_t ACT_LOAD   = 2'd2;
	localparam action_t ACT_COMMIT = 2'd3;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_JOY_LOW  = 1'd0;
	localparam cfg_idx_t CFG_JOY_HIGH = 1'd1;

	typedef logic [2:0] cursor_t;
	localparam cursor_t CUR_YEAR   = 3'd0;
	localparam cursor_t CUR_MONTH  = 3'd1;
	localparam cursor_t CUR_DAY    = 3'd2;
	localparam cursor_t CUR_HOUR   = 3'd3;
	localparam cursor_t CUR_MINUTE = 3'd4;
	localparam cursor_t CUR_SECOND = 3'd5;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		cursor_t     cursor;
	} cal_t;

	typedef struct packed {
		logic [7:0]       elapsed_seconds;
		logic [JOY_W-1:0] joy_x;
		logic [JOY_W-1:0] joy_y;
		logic [13:0]      load_year;
		logic [3:0]       load_month;
		logic [4:0]       load_day;
		logic [4:0]       load_hour;
		logic [5:0]       load_minute;
		logic [5:0]       load_second;
	} item_t;

	// y/100 by reciprocal (5243 / 2^19), exact for any 14-bit year
	function automatic logic is_leap(input logic [13:0] y);
		logic [26:0] prod;
		logic [7:0]  q;
		logic [14:0] hund;
		logic [14:0] rem;
		prod = 27'(y) * 27'd5243;
		q    = prod[26:19];
		hund = 15'(q) * 15'd100;
		rem  = 15'(y) - hund;
		return (y[1:0] == 2'b00) && ((rem != 15'd0) || (q[1:0] == 2'b00));
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m) inside
			4'd2:                    d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

	// minute carry out of a seconds sum of at most 314
	function automatic logic [2:0] sec_carry(input logic [8:0] s);
		logic [2:0] c;
		if (s >= 9'd300)      c = 3'd5;
		else if (s >= 9'd240) c = 3'd4;
		else if (s >= 9'd180) c = 3'd3;
		else if (s >= 9'd120) c = 3'd2;
		else if (s >= 9'd60)  c = 3'd1;
		else                  c = 3'd0;
		return c;
	endfunction

endpackage

// ----- design/cte_next.sv -----
// next calendar state and commit flag for one item
module cte_next #(
	parameter int ADC_BITS = cte_pkg::ADC_BITS_DEF
) (
	input  cte_pkg::cal_t              cur,
	input  cte_pkg::action_t           action,
	input  cte_pkg::item_t             item,
	input  logic [cte_pkg::JOY_W-1:0]  joy_low,
	input  logic [cte_pkg::JOY_W-1:0]  joy_high,
	output cte_pkg::cal_t              nxt,
	output logic                       commit
);
	import cte_pkg::*;

	localparam int CMP_W = (ADC_BITS < JOY_W) ? ADC_BITS : JOY_W;

	logic       leap_cur;
	logic [4:0] dim_cur;
	cal_t       tick_cal;
	cal_t       step_cal;
	cal_t       joy_cal;
	cal_t       load_cal;

	logic [8:0] sec_sum;
	logic [2:0] sec_c;
	logic [8:0] sec_rem;
	logic [6:0] min_sum;
	logic [4:0] hour_sum;
	logic       hour_c;
	logic [5:0] day_sum;

	logic       x_left, x_right, y_up, y_down;
	logic       leap_step;
	logic [4:0] dim_step;
	logic       leap_ld;
	logic [4:0] dim_ld;

	assign leap_cur = is_leap(cur.year);
	assign dim_cur  = days_in(cur.month, leap_cur);

	// tick: at most one day of carry, so a single month roll is enough
	always_comb begin
		tick_cal = cur;
		sec_sum  = 9'(cur.second) + 9'(item.elapsed_seconds);
		sec_c    = sec_carry(sec_sum);
		sec_rem  = sec_sum - 9'(sec_c) * 9'd60;
		tick_cal.second = sec_rem[5:0];
		min_sum  = 7'(cur.minute) + 7'(sec_c);
		hour_sum = cur.hour;
		if (min_sum >= 7'd60) begin
			tick_cal.minute = 6'(min_sum - 7'd60);
			hour_sum = cur.hour + 5'd1;
		end else begin
			tick_cal.minute = min_sum[5:0];
		end
		hour_c = (hour_sum >= 5'd24);
		tick_cal.hour = hour_c ? 5'd0 : hour_sum;
		day_sum = 6'(cur.day) + 6'(hour_c);
		if (day_sum > 6'(dim_cur)) begin
			tick_cal.day = 5'd1;
			if (cur.month >= MONTH_MAX) begin
				tick_cal.month = 4'd1;
				if (cur.year < YEAR_MAX) tick_cal.year = cur.year + 14'd1;
			end else begin
				tick_cal.month = cur.month + 4'd1;
			end
		end else begin
			tick_cal.day = day_sum[4:0];
		end
	end

	assign x_left  = item.joy_x[CMP_W-1:0] < joy_low[CMP_W-1:0];
	assign x_right = !x_left && (item.joy_x[CMP_W-1:0] > joy_high[CMP_W-1:0]);
	assign y_up    = item.joy_y[CMP_W-1:0] < joy_low[CMP_W-1:0];
	assign y_down  = !y_up && (item.joy_y[CMP_W-1:0] > joy_high[CMP_W-1:0]);

	// joystick: cursor move, then step the selected field
	always_comb begin
		step_cal = cur;
		if (x_left && cur.cursor > CUR_YEAR)
			step_cal.cursor = cur.cursor - 3'd1;
		else if (x_right && cur.cursor < CUR_SECOND)
			step_cal.cursor = cur.cursor + 3'd1;
		if (y_up || y_down) begin
			case (step_cal.cursor)
				CUR_YEAR: begin
					if (y_up && cur.year < YEAR_MAX) step_cal.year = cur.year + 14'd1;
					else if (y_down && cur.year != 14'd0) step_cal.year = cur.year - 14'd1;
				end
				CUR_MONTH: begin
					if (y_up) step_cal.month = (cur.month >= MONTH_MAX) ? 4'd1 : cur.month + 4'd1;
					else      step_cal.month = (cur.month <= 4'd1) ? MONTH_MAX : cur.month - 4'd1;
				end
				CUR_DAY: begin
					if (y_up) step_cal.day = (cur.day >= dim_cur) ? 5'd1 : cur.day + 5'd1;
					else      step_cal.day = (cur.day <= 5'd1) ? dim_cur : cur.day - 5'd1;
				end
				CUR_HOUR: begin
					if (y_up) step_cal.hour = (cur.hour >= HOUR_MAX) ? 5'd0 : cur.hour + 5'd1;
					else      step_cal.hour = (cur.hour == 5'd0) ? HOUR_MAX : cur.hour - 5'd1;
				end
				CUR_MINUTE: begin
					if (y_up) step_cal.minute = (cur.minute >= MINSEC_MAX) ? 6'd0 : cur.minute + 6'd1;
					else      step_cal.minute = (cur.minute == 6'd0) ? MINSEC_MAX : cur.minute - 6'd1;
				end
				default: begin
					if (y_up) step_cal.second = (cur.second >= MINSEC_MAX) ? 6'd0 : cur.second + 6'd1;
					else      step_cal.second = (cur.second == 6'd0) ? MINSEC_MAX : cur.second - 6'd1;
				end
			endcase
		end
	end

	assign leap_step = is_leap(step_cal.year);
	assign dim_step  = days_in(step_cal.month, leap_step);

	always_comb begin
		joy_cal = step_cal;
		if (step_cal.day > dim_step) joy_cal.day = dim_step;
	end

	// load: every field clamped into range, cursor to hour
	always_comb begin
		load_cal.year   = (item.load_year > YEAR_MAX) ? YEAR_MAX : item.load_year;
		if (item.load_month == 4'd0)          load_cal.month = 4'd1;
		else if (item.load_month > MONTH_MAX) load_cal.month = MONTH_MAX;
		else                                  load_cal.month = item.load_month;
		load_cal.hour   = (item.load_hour > HOUR_MAX) ? HOUR_MAX : item.load_hour;
		load_cal.minute = (item.load_minute > MINSEC_MAX) ? MINSEC_MAX : item.load_minute;
		load_cal.second = (item.load_second > MINSEC_MAX) ? MINSEC_MAX : item.load_second;
		load_cal.cursor = CUR_HOUR;
		leap_ld = is_leap(load_cal.year);
		dim_ld  = days_in(load_cal.month, leap_ld);
		if (item.load_day == 5'd0)        load_cal.day = 5'd1;
		else if (item.load_day > dim_ld)  load_cal.day = dim_ld;
		else                              load_cal.day = item.load_day;
	end

	always_comb begin
		commit = 1'b0;
		case (action)
			ACT_TICK: nxt = tick_cal;
			ACT_JOY:  nxt = joy_cal;
			ACT_LOAD: nxt = load_cal;
			default: begin
				nxt    = cur;
				commit = 1'b1;
			end
		endcase
	end

endmodule

// ----- design/calendar_time_editor_unit.sv -----
// editable calendar clock: input register, next-state logic, result register
// path: an accepted beat is registered in the input stage, then in the result register that drives m_axis
// throughput: one beat per cycle while m_axis takes results; the only loop is the calendar state register
// the input stage takes a new beat while a finished result waits on m_axis, if the input stage is empty
// reset: date 2026-01-01 00:00:00, cursor on year, thresholds 1000 and 3000
module calendar_time_editor_unit #(
	parameter int ADC_BITS = cte_pkg::ADC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// elapsed_seconds, joy_x, joy_y, load_year, load_month, load_day,
	// load_hour, load_minute, load_second
	input  logic [cte_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// action
	input  logic [cte_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// out_year, out_month, out_day, out_hour, out_minute, out_second,
	// cursor_field, zero fill
	output logic [cte_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// commit_strobe
	output logic [cte_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cte_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cte_pkg::JOY_W-1:0]          cfg_data
);
	import cte_pkg::*;

	logic [JOY_W-1:0] joy_low_q, joy_high_q;

	logic    valid_s1;
	action_t action_s1;
	item_t   item_s1;
	item_t   item_in;

	cal_t    cal_q;
	logic    commit_q;
	logic    out_valid_q;
	cal_t    cal_nxt;
	logic    commit_nxt;
	logic    adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joy_low_q  <= JOY_LOW_RST;
			joy_high_q <= JOY_HIGH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_JOY_LOW:  joy_low_q  <= cfg_data;
				CFG_JOY_HIGH: joy_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_in.elapsed_seconds = s_axis_tdata[7:0];
	assign item_in.joy_x           = s_axis_tdata[19:8];
	assign item_in.joy_y           = s_axis_tdata[31:20];
	assign item_in.load_year       = s_axis_tdata[45:32];
	assign item_in.load_month      = s_axis_tdata[49:46];
	assign item_in.load_day        = s_axis_tdata[54:50];
	assign item_in.load_hour       = s_axis_tdata[59:55];
	assign item_in.load_minute     = s_axis_tdata[65:60];
	assign item_in.load_second     = s_axis_tdata[71:66];

	// result stage moves when its register is empty or being drained
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= s_axis_tuser[1:0];
			item_s1   <= item_in;
		end
	end

	cte_next #(
		.ADC_BITS (ADC_BITS)
	) u_next (
		.cur      (cal_q),
		.action   (action_s1),
		.item     (item_s1),
		.joy_low  (joy_low_q),
		.joy_high (joy_high_q),
		.nxt      (cal_nxt),
		.commit   (commit_nxt)
	);

	// calendar state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.year   <= YEAR_RST;
			cal_q.month  <= 4'd1;
			cal_q.day    <= 5'd1;
			cal_q.hour   <= 5'd0;
			cal_q.minute <= 6'd0;
			cal_q.second <= 6'd0;
			cal_q.cursor <= CUR_YEAR;
			commit_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				cal_q    <= cal_nxt;
				commit_q <= commit_nxt;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, cal_q.cursor, cal_q.second, cal_q.minute, cal_q.hour,
		cal_q.day, cal_q.month, cal_q.year};
	assign m_axis_tuser  = commit_q;

`ifndef SYNTHESIS
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_q.year <= YEAR_MAX && cal_q.month >= 4'd1 && cal_q.month <= MONTH_MAX &&
		cal_q.hour <= HOUR_MAX && cal_q.minute <= MINSEC_MAX &&
		cal_q.second <= MINSEC_MAX && cal_q.cursor <= CUR_SECOND)
		else $error("calendar state out of range");

	a_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cal_q.day >= 5'd1 && cal_q.day <= days_in(cal_q.month, is_leap(cal_q.year)))
		else $error("day beyond month length");

	a_commit_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && action_s1 == ACT_COMMIT |=> cal_q == $past(cal_q) && commit_q)
		else $error("commit changed the calendar state");

	a_load_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && action_s1 == ACT_LOAD |=> cal_q.cursor == CUR_HOUR && !commit_q)
		else $error("load did not move cursor to hour");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1) && $stable(action_s1))
		else $error("input stage lost a waiting beat");
`endif

endmodule
